@@ rtl/core/lcdr_pkg.sv @@
package lcdr_pkg;

   localparam int DEF_ROWS = 4;
   localparam int DEF_COLUMNS = 16;
   localparam int DEF_UNLOCK_STROKES = 16;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_PULSE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNLOCK_PULSE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMAND_SETTLE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLEAR_SETTLE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_WAIT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_BASE = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKLIGHT = 3'd6;

   localparam logic [15:0] RST_ENABLE_PULSE = 16'd150;
   localparam logic [15:0] RST_UNLOCK_PULSE = 16'd1000;
   localparam logic [15:0] RST_COMMAND_SETTLE = 16'd1500;
   localparam logic [15:0] RST_CLEAR_SETTLE = 16'd3000;
   localparam logic [23:0] RST_POWER_WAIT = 24'd2000000;
   localparam logic [31:0] RST_ROW_BASE = 32'd3499147392;
   localparam logic [15:0] RST_BACKLIGHT = 16'd60;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_HASH = 8'h23;

   localparam logic [7:0] CMD_FUNCTION = 8'h28;
   localparam logic [7:0] CMD_SHIFT = 8'h14;
   localparam logic [7:0] CMD_CLEAR = 8'h01;
   localparam logic [7:0] CMD_HOME = 8'h02;
   localparam logic [7:0] CMD_ENTRY = 8'h06;
   localparam logic [7:0] CMD_DISPLAY = 8'h0C;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef struct packed {
      logic        register_select;
      logic        read_write;
      logic        enable_pin;
      logic [3:0]  data_nibble;
      logic        power_on;
      logic [15:0] backlight;
      logic        initialized;
   } result_type;

endpackage

@@ rtl/core/lcdr_screen_mem.sv @@
module lcdr_screen_mem #(
   parameter int CELLS = 64,
   parameter int IDX_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] rd_idx,
   input  logic             hw_en,
   input  logic [IDX_W-1:0] hw_idx,
   input  logic [7:0]       hw_data,
   input  logic             fill_en,
   input  logic [7:0]       fill_data,
   input  logic             sw_en,
   input  logic [IDX_W-1:0] sw_idx,
   input  logic [7:0]       sw_data,
   output logic [7:0]       buf_cur,
   output logic [7:0]       buf_succ,
   output logic [7:0]       shown_cur
);
   import lcdr_pkg::*;

   // Buffer entries whose flag is set read as the fill value; shadow entries as spaces.
   logic [7:0] buf_mem [CELLS];
   logic [7:0] shown_mem [CELLS];
   logic [CELLS-1:0] bflag_ff;
   logic [CELLS-1:0] sflag_ff;
   logic [7:0] fill_ff;
   logic [IDX_W-1:0] ra_ff;
   logic [7:0] bufa_ff, bufb_ff, shd_ff;
   logic [IDX_W-1:0] rd_succ, ra_succ;

   function automatic logic [IDX_W-1:0] succ(input logic [IDX_W-1:0] i);
      succ = (i == IDX_W'(CELLS - 1)) ? '0 : i + 1'b1;
   endfunction

   assign rd_succ = succ(rd_idx);
   assign ra_succ = succ(ra_ff);

   always_ff @(posedge clock) begin
      if (hw_en) begin
         buf_mem[hw_idx] <= hw_data;
      end
      if (sw_en) begin
         shown_mem[sw_idx] <= sw_data;
      end
      bufa_ff <= (hw_en && hw_idx == rd_idx) ? hw_data : buf_mem[rd_idx];
      bufb_ff <= (hw_en && hw_idx == rd_succ) ? hw_data : buf_mem[rd_succ];
      shd_ff <= (sw_en && sw_idx == rd_idx) ? sw_data : shown_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bflag_ff <= '1;
         sflag_ff <= '1;
         fill_ff <= CHAR_SPACE;
         ra_ff <= '0;
      end else begin
         ra_ff <= rd_idx;
         if (fill_en) begin
            bflag_ff <= '1;
            fill_ff <= fill_data;
         end else if (hw_en) begin
            bflag_ff[hw_idx] <= 1'b0;
         end
         if (sw_en) begin
            sflag_ff[sw_idx] <= 1'b0;
         end
      end
   end

   assign buf_cur = bflag_ff[ra_ff] ? fill_ff : bufa_ff;
   assign buf_succ = bflag_ff[ra_succ] ? fill_ff : bufb_ff;
   assign shown_cur = sflag_ff[ra_ff] ? CHAR_SPACE : shd_ff;

endmodule

@@ rtl/core/lcdr_sequencer.sv @@
module lcdr_sequencer #(
   parameter int ROWS = 4,
   parameter int COLUMNS = 16,
   parameter int UNLOCK_STROKES = 16,
   parameter int CELLS = 64,
   parameter int IDX_W = 6
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [lcdr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lcdr_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                             accept,
   input  logic                             operation,
   input  logic [1:0]                       row,
   input  logic [3:0]                       column,
   input  logic [7:0]                       character,
   input  logic [7:0]                       buf_cur,
   input  logic [7:0]                       buf_succ,
   input  logic [7:0]                       shown_cur,
   output logic [IDX_W-1:0]                 rd_idx,
   output logic                             hw_en,
   output logic [IDX_W-1:0]                 hw_idx,
   output logic [7:0]                       hw_data,
   output logic                             fill_en,
   output logic [7:0]                       fill_data,
   output logic                             sw_en,
   output logic [IDX_W-1:0]                 sw_idx,
   output logic [7:0]                       sw_data,
   output lcdr_pkg::result_type             result
);
   import lcdr_pkg::*;

   localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int UNL_W = $clog2(UNLOCK_STROKES + 1);
   localparam int STEP_W = $clog2(2 * CELLS + 2);

   localparam logic [3:0] PH_POWER_OFF = 4'd0;
   localparam logic [3:0] PH_UNLOCK_HI = 4'd1;
   localparam logic [3:0] PH_UNLOCK_LO = 4'd2;
   localparam logic [3:0] PH_POWER_ON = 4'd3;
   localparam logic [3:0] PH_FUNCTION = 4'd4;
   localparam logic [3:0] PH_SHIFT = 4'd5;
   localparam logic [3:0] PH_CLEAR = 4'd6;
   localparam logic [3:0] PH_HOME = 4'd7;
   localparam logic [3:0] PH_ENTRY = 4'd8;
   localparam logic [3:0] PH_DISPLAY = 4'd9;
   localparam logic [3:0] PH_FILL = 4'd10;
   localparam logic [3:0] PH_WINDOW = 4'd11;
   localparam logic [3:0] PH_PASS = 4'd12;
   localparam logic [3:0] PH_FINAL = 4'd13;

   localparam logic [1:0] NIB_SPLIT = 2'd0;
   localparam logic [1:0] NIB_HIGH = 2'd1;
   localparam logic [1:0] NIB_LOW = 2'd2;

   localparam logic [1:0] STB_SETUP = 2'd0;
   localparam logic [1:0] STB_RISE = 2'd1;
   localparam logic [1:0] STB_FALL = 2'd2;
   localparam logic [1:0] STB_END = 2'd3;

   logic [15:0] enable_pulse_ff, unlock_pulse_ff, command_settle_ff, clear_settle_ff;
   logic [23:0] power_wait_ff;
   logic [31:0] row_base_ff;
   logic [15:0] backlight_level_ff;

   logic [3:0] phase_ff, phase_in;
   logic [UNL_W-1:0] unlock_ff, unlock_in;
   logic [1:0] pass_ff, pass_in;
   logic toggle_ff, toggle_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [31:0] delay_count_ff, delay_count_in;
   logic delay_active_ff, delay_active_in;
   logic [15:0] scount_ff, scount_in;
   logic sact_ff, sact_in;
   logic [1:0] nib_ff, nib_in;
   logic [1:0] sstep_ff, sstep_in;
   logic [7:0] held_ff, held_in;
   logic byte_done_ff, byte_done_in;
   logic sending_ff, sending_in;
   logic pending_ff, pending_in;
   logic [1:0] crow_ff, crow_in;
   logic [COL_W-1:0] ccol_ff, ccol_in;
   logic [7:0] pins_ff, pins_in;
   logic init_ff, init_in;
   logic [15:0] backlight_ff, backlight_in;

   logic tick;
   logic hit_enable, hit_unlock, hit_command, hit_clear, hit_power;
   logic do_wait, wait_hit, do_send, send_rs, do_refresh, advanced, cmd_hit;
   logic [7:0] send_val, position, base_byte, cmd_code;
   logic [3:0] nibble;

   function automatic logic [IDX_W-1:0] cell_index(input logic [1:0] r,
                                                   input logic [COL_W-1:0] c);
      cell_index = IDX_W'(IDX_W'(r) * IDX_W'(COLUMNS) + IDX_W'(c));
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_pulse_ff <= RST_ENABLE_PULSE;
         unlock_pulse_ff <= RST_UNLOCK_PULSE;
         command_settle_ff <= RST_COMMAND_SETTLE;
         clear_settle_ff <= RST_CLEAR_SETTLE;
         power_wait_ff <= RST_POWER_WAIT;
         row_base_ff <= RST_ROW_BASE;
         backlight_level_ff <= RST_BACKLIGHT;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ENABLE_PULSE: enable_pulse_ff <= csr_write_data[15:0];
            CSR_UNLOCK_PULSE: unlock_pulse_ff <= csr_write_data[15:0];
            CSR_COMMAND_SETTLE: command_settle_ff <= csr_write_data[15:0];
            CSR_CLEAR_SETTLE: clear_settle_ff <= csr_write_data[15:0];
            CSR_POWER_WAIT: power_wait_ff <= csr_write_data[23:0];
            CSR_ROW_BASE: row_base_ff <= csr_write_data;
            CSR_BACKLIGHT: backlight_level_ff <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   assign tick = accept && (operation == OP_TICK);
   assign hit_enable = delay_count_ff >= 32'(enable_pulse_ff);
   assign hit_unlock = delay_count_ff >= 32'(unlock_pulse_ff);
   assign hit_command = delay_count_ff >= 32'(command_settle_ff);
   assign hit_clear = delay_count_ff >= 32'(clear_settle_ff);
   assign hit_power = delay_count_ff >= 32'(power_wait_ff);

   always_comb begin
      case (crow_ff)
         2'd0: base_byte = row_base_ff[7:0];
         2'd1: base_byte = row_base_ff[15:8];
         2'd2: base_byte = row_base_ff[23:16];
         default: base_byte = row_base_ff[31:24];
      endcase
      case (phase_ff)
         PH_FUNCTION: begin cmd_code = CMD_FUNCTION; cmd_hit = hit_command; end
         PH_SHIFT: begin cmd_code = CMD_SHIFT; cmd_hit = hit_command; end
         PH_CLEAR: begin cmd_code = CMD_CLEAR; cmd_hit = hit_clear; end
         PH_HOME: begin cmd_code = CMD_HOME; cmd_hit = hit_clear; end
         PH_ENTRY: begin cmd_code = CMD_ENTRY; cmd_hit = hit_command; end
         default: begin cmd_code = CMD_DISPLAY; cmd_hit = hit_command; end
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      unlock_in = unlock_ff;
      pass_in = pass_ff;
      toggle_in = toggle_ff;
      step_in = step_ff;
      delay_count_in = delay_count_ff;
      delay_active_in = delay_active_ff;
      scount_in = scount_ff;
      sact_in = sact_ff;
      nib_in = nib_ff;
      sstep_in = sstep_ff;
      held_in = held_ff;
      byte_done_in = byte_done_ff;
      sending_in = sending_ff;
      pending_in = pending_ff;
      crow_in = crow_ff;
      ccol_in = ccol_ff;
      pins_in = pins_ff;
      init_in = init_ff;
      backlight_in = backlight_ff;
      do_wait = 1'b0;
      wait_hit = 1'b0;
      do_send = 1'b0;
      send_rs = 1'b0;
      send_val = '0;
      do_refresh = 1'b0;
      advanced = 1'b0;
      position = '0;
      nibble = '0;
      fill_en = 1'b0;
      sw_en = 1'b0;

      if (tick) begin
         if (init_ff) begin
            do_refresh = 1'b1;
         end else begin
            backlight_in = '0;
            case (phase_ff)
               PH_POWER_OFF: begin
                  pins_in[7] = 1'b0;
                  do_wait = 1'b1;
                  wait_hit = hit_power;
                  if (hit_power) begin
                     phase_in = PH_UNLOCK_HI;
                  end
               end
               PH_UNLOCK_HI: begin
                  pins_in = {pins_ff[7], 7'b0000100};
                  do_wait = 1'b1;
                  wait_hit = hit_unlock;
                  if (hit_unlock) begin
                     phase_in = PH_UNLOCK_LO;
                  end
               end
               PH_UNLOCK_LO: begin
                  pins_in = {pins_ff[7], 7'b0};
                  do_wait = 1'b1;
                  wait_hit = hit_unlock;
                  if (hit_unlock) begin
                     if (unlock_ff + 1'b1 < UNL_W'(UNLOCK_STROKES)) begin
                        unlock_in = unlock_ff + 1'b1;
                        phase_in = PH_UNLOCK_HI;
                     end else begin
                        unlock_in = '0;
                        phase_in = PH_POWER_ON;
                     end
                  end
               end
               PH_POWER_ON: begin
                  pins_in[7] = 1'b1;
                  do_wait = 1'b1;
                  wait_hit = hit_power;
                  if (hit_power) begin
                     phase_in = PH_FUNCTION;
                  end
               end
               PH_FUNCTION, PH_SHIFT, PH_CLEAR, PH_HOME, PH_ENTRY, PH_DISPLAY: begin
                  if (byte_done_ff) begin
                     do_wait = 1'b1;
                     wait_hit = cmd_hit;
                     if (cmd_hit) begin
                        phase_in = phase_ff + 1'b1;
                        byte_done_in = 1'b0;
                     end
                  end else begin
                     do_send = 1'b1;
                     send_val = cmd_code;
                  end
               end
               PH_FILL: begin
                  fill_en = 1'b1;
                  toggle_in = ~toggle_ff;
                  phase_in = PH_WINDOW;
               end
               PH_WINDOW: begin
                  delay_active_in = 1'b1;
                  if (hit_clear) begin
                     if (step_ff + 1'b1 > STEP_W'(2 * CELLS)) begin
                        phase_in = PH_PASS;
                        crow_in = '0;
                        ccol_in = '0;
                        step_in = '0;
                     end else begin
                        step_in = step_ff + 1'b1;
                     end
                  end else begin
                     do_refresh = 1'b1;
                  end
               end
               PH_PASS: begin
                  if (pass_ff != '0) begin
                     phase_in = PH_FINAL;
                     pass_in = '0;
                  end else begin
                     pass_in = pass_ff + 1'b1;
                     phase_in = PH_FUNCTION;
                  end
               end
               PH_FINAL: begin
                  do_wait = 1'b1;
                  wait_hit = hit_power;
                  if (hit_power) begin
                     phase_in = PH_POWER_OFF;
                     init_in = 1'b1;
                     sending_in = 1'b0;
                     backlight_in = backlight_level_ff;
                  end
               end
               default: phase_in = PH_POWER_OFF;
            endcase
         end

         if (do_refresh) begin
            if (shown_cur != buf_cur) begin
               pending_in = 1'b1;
               position = base_byte + 8'(ccol_ff);
            end else begin
               advanced = 1'b1;
               if (ccol_ff == COL_W'(COLUMNS - 1)) begin
                  ccol_in = '0;
                  crow_in = (crow_ff == 2'(ROWS - 1)) ? 2'd0 : crow_ff + 1'b1;
               end else begin
                  ccol_in = ccol_ff + 1'b1;
               end
            end
            if (pending_in) begin
               if (byte_done_ff) begin
                  do_wait = 1'b1;
                  wait_hit = hit_enable;
                  if (hit_enable) begin
                     byte_done_in = 1'b0;
                     sending_in = ~sending_ff;
                     if (sending_ff) begin
                        pending_in = 1'b0;
                        sw_en = 1'b1;
                     end
                  end
               end else begin
                  do_send = 1'b1;
                  send_rs = sending_ff;
                  send_val = sending_ff ? buf_cur : position;
               end
            end
         end

         if (do_send) begin
            if (nib_ff != NIB_HIGH && nib_ff != NIB_LOW) begin
               held_in = send_val;
               nib_in = NIB_HIGH;
            end else if (sstep_ff == STB_SETUP) begin
               nibble = (nib_ff == NIB_HIGH) ? held_ff[7:4] : held_ff[3:0];
               pins_in = {pins_ff[7], nibble, pins_ff[2], 1'b0, send_rs};
               sstep_in = STB_RISE;
               scount_in = '0;
               sact_in = 1'b1;
            end else if (scount_ff >= enable_pulse_ff) begin
               scount_in = '0;
               case (sstep_ff)
                  STB_RISE: begin
                     pins_in[2] = 1'b1;
                     sstep_in = STB_FALL;
                  end
                  STB_FALL: begin
                     pins_in[2] = 1'b0;
                     sstep_in = STB_END;
                  end
                  default: begin
                     sact_in = 1'b0;
                     sstep_in = STB_SETUP;
                     if (nib_ff == NIB_HIGH) begin
                        nib_in = NIB_LOW;
                        byte_done_in = 1'b0;
                     end else begin
                        nib_in = NIB_SPLIT;
                        byte_done_in = 1'b1;
                     end
                  end
               endcase
            end
         end

         if (do_wait) begin
            delay_active_in = ~wait_hit;
            if (wait_hit) begin
               delay_count_in = '0;
            end
         end
         if (delay_active_in) begin
            delay_count_in = delay_count_in + 1'b1;
         end
         if (sact_in) begin
            scount_in = scount_in + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_POWER_OFF;
         unlock_ff <= '0;
         pass_ff <= '0;
         toggle_ff <= 1'b0;
         step_ff <= '0;
         delay_count_ff <= '0;
         delay_active_ff <= 1'b0;
         scount_ff <= '0;
         sact_ff <= 1'b0;
         nib_ff <= NIB_SPLIT;
         sstep_ff <= STB_SETUP;
         held_ff <= '0;
         byte_done_ff <= 1'b0;
         sending_ff <= 1'b0;
         pending_ff <= 1'b0;
         crow_ff <= '0;
         ccol_ff <= '0;
         pins_ff <= '0;
         init_ff <= 1'b0;
         backlight_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         unlock_ff <= unlock_in;
         pass_ff <= pass_in;
         toggle_ff <= toggle_in;
         step_ff <= step_in;
         delay_count_ff <= delay_count_in;
         delay_active_ff <= delay_active_in;
         scount_ff <= scount_in;
         sact_ff <= sact_in;
         nib_ff <= nib_in;
         sstep_ff <= sstep_in;
         held_ff <= held_in;
         byte_done_ff <= byte_done_in;
         sending_ff <= sending_in;
         pending_ff <= pending_in;
         crow_ff <= crow_in;
         ccol_ff <= ccol_in;
         pins_ff <= pins_in;
         init_ff <= init_in;
         backlight_ff <= backlight_in;
      end
   end

   assign rd_idx = cell_index(crow_in, ccol_in);
   assign sw_idx = rd_idx;
   assign sw_data = advanced ? buf_succ : buf_cur;
   assign fill_data = toggle_ff ? CHAR_SPACE : CHAR_HASH;
   assign hw_en = accept && (operation == OP_WRITE) && (32'(row) < ROWS)
                  && (32'(column) < COLUMNS);
   assign hw_idx = IDX_W'(IDX_W'(row) * IDX_W'(COLUMNS) + IDX_W'(column));
   assign hw_data = character;

   assign result.register_select = pins_in[0];
   assign result.read_write = 1'b0;
   assign result.enable_pin = pins_in[2];
   assign result.data_nibble = pins_in[6:3];
   assign result.power_on = pins_in[7];
   assign result.backlight = backlight_in;
   assign result.initialized = init_in;

endmodule

@@ rtl/core/lcdr_out_skid.sv @@
module lcdr_out_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  lcdr_pkg::result_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output lcdr_pkg::result_type out_data
);
   import lcdr_pkg::*;

   logic out_valid_ff, skid_valid_ff;
   result_type out_ff, skid_ff;
   logic accept;

   assign in_ready = ~skid_valid_ff;
   assign accept = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
            out_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || out_ready) begin
         out_ff <= skid_valid_ff ? skid_ff : in_data;
      end else if (accept) begin
         skid_ff <= in_data;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data = out_ff;

endmodule

@@ rtl/core/char_lcd_4bit_refresh_controller.sv @@
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    operation, row, column, character
// rsp_      out        rsp_valid/rsp_ready    LCD pin levels, backlight, initialized
// csr_      in         csr_write_enable       csr_index, csr_write_data
//
// One item is accepted per clock while req_ready is high; its result is registered in
// the output register, or held in the one-entry skid stage while the result side stalls.
// The buffer and shadow screens live in two memories with a registered read, read
// ahead at the next cursor cell with write forwarding. Reset is synchronous and marks
// both screens as blank through per-cell flags, so no clearing pass is needed.
// A stalled result side holds one further item in the skid stage, then stops req_ready.
module char_lcd_4bit_refresh_controller #(
   parameter int ROWS = lcdr_pkg::DEF_ROWS,
   parameter int COLUMNS = lcdr_pkg::DEF_COLUMNS,
   parameter int UNLOCK_STROKES = lcdr_pkg::DEF_UNLOCK_STROKES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [lcdr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lcdr_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_operation,
   input  logic [1:0]                       req_row,
   input  logic [3:0]                       req_column,
   input  logic [7:0]                       req_character,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_register_select,
   output logic                             rsp_read_write,
   output logic                             rsp_enable_pin,
   output logic [3:0]                       rsp_data_nibble,
   output logic                             rsp_power_on,
   output logic [15:0]                      rsp_backlight,
   output logic                             rsp_initialized
);
   import lcdr_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;

   logic accept;
   logic [IDX_W-1:0] rd_idx, hw_idx, sw_idx;
   logic hw_en, fill_en, sw_en;
   logic [7:0] hw_data, fill_data, sw_data, buf_cur, buf_succ, shown_cur;
   result_type result, rsp_data;

   assign accept = req_valid && req_ready;

   lcdr_sequencer #(
      .ROWS(ROWS),
      .COLUMNS(COLUMNS),
      .UNLOCK_STROKES(UNLOCK_STROKES),
      .CELLS(CELLS),
      .IDX_W(IDX_W)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .accept(accept),
      .operation(req_operation),
      .row(req_row),
      .column(req_column),
      .character(req_character),
      .buf_cur(buf_cur),
      .buf_succ(buf_succ),
      .shown_cur(shown_cur),
      .rd_idx(rd_idx),
      .hw_en(hw_en),
      .hw_idx(hw_idx),
      .hw_data(hw_data),
      .fill_en(fill_en),
      .fill_data(fill_data),
      .sw_en(sw_en),
      .sw_idx(sw_idx),
      .sw_data(sw_data),
      .result(result)
   );

   lcdr_screen_mem #(
      .CELLS(CELLS),
      .IDX_W(IDX_W)
   ) u_mem (
      .clock(clock),
      .reset(reset),
      .rd_idx(rd_idx),
      .hw_en(hw_en),
      .hw_idx(hw_idx),
      .hw_data(hw_data),
      .fill_en(fill_en),
      .fill_data(fill_data),
      .sw_en(sw_en),
      .sw_idx(sw_idx),
      .sw_data(sw_data),
      .buf_cur(buf_cur),
      .buf_succ(buf_succ),
      .shown_cur(shown_cur)
   );

   lcdr_out_skid u_out (
      .clock(clock),
      .reset(reset),
      .in_valid(req_valid),
      .in_ready(req_ready),
      .in_data(result),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .out_data(rsp_data)
   );

   assign rsp_register_select = rsp_data.register_select;
   assign rsp_read_write = rsp_data.read_write;
   assign rsp_enable_pin = rsp_data.enable_pin;
   assign rsp_data_nibble = rsp_data.data_nibble;
   assign rsp_power_on = rsp_data.power_on;
   assign rsp_backlight = rsp_data.backlight;
   assign rsp_initialized = rsp_data.initialized;

endmodule
